[hdl/rpb_pkg.sv]
// Shared types, constants and register codes of the ROM prefetch buffer timing unit.
package rpb_pkg;

	localparam int RPB_BUFFER_DEPTH = 16;
	localparam int RPB_QUEUE_DEPTH  = 2;

	localparam logic [27:0] ROM_BASE_ADDR = 28'h800_0000;
	localparam logic [27:0] BLOCK_MASK    = 28'h001_FFFF;

	localparam logic [3:0] SEQ_WAIT_RESET    = 4'd1;
	localparam logic [3:0] NONSEQ_WAIT_RESET = 4'd4;

	typedef enum logic {
		REG_SEQ_WAIT    = 1'b0,
		REG_NONSEQ_WAIT = 1'b1
	} reg_index_t;

	// Wait-state configuration seen by the back end.
	typedef struct packed {
		logic [3:0] seq_wait;
		logic [3:0] nonseq_wait;
	} cfg_t;

	// One classified fetch as it travels from the front end to the back end.
	typedef struct packed {
		logic        word;
		logic [27:0] address;
		logic        sequential;
		logic [31:0] now;
		logic        blk_start;
		logic [24:0] rom_offset;
	} rpb_entry_t;

endpackage

[hdl/rom_prefetch_buffer_timing_unit.sv]
// Top level of the ROM prefetch buffer timing unit: config registers, front end, queue, back end.
//
// Timing model of a cartridge ROM prefetch buffer. Each input word is a halfword
// (kind 0) or word (kind 1) fetch with its address, the bus sequential flag and the
// current cycle count; each produces exactly one result word with the stall cycles
// to add and the 25-bit ROM byte offset. A front stage registers and classifies the
// fetch (offset, 128 KiB block start) and pushes it into a short queue; the back end
// pops it, then advances the buffer one halfword per cycle for every sequential access
// time elapsed since the last fill, and then resolves hit or miss. The fill sequencer
// adds 0 to BUFFER_DEPTH halfwords per fetch. The result sits in an output register,
// so the back end picks up the next fetch while a result waits. Write seq_wait (index 0)
// and nonseq_wait (index 1) through cfg_wr_en/cfg_index/cfg_data only while the unit
// is idle; they reset to 1 and 4.
module rom_prefetch_buffer_timing_unit
	import rpb_pkg::*;
#(
	parameter int BUFFER_DEPTH = RPB_BUFFER_DEPTH,
	parameter int QUEUE_DEPTH  = RPB_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [27:0] address,
	input  logic        sequential,
	input  logic [31:0] now,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  stall_res,
	output logic [24:0] rom_offset
);

	cfg_t       cfg_q;
	logic       push;
	rpb_entry_t push_data;
	logic       q_full;
	logic       q_empty;
	logic       pop;
	rpb_entry_t q_data;

	// hold the wait-state registers; decode the index by name
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.seq_wait    <= SEQ_WAIT_RESET;
			cfg_q.nonseq_wait <= NONSEQ_WAIT_RESET;
		end else if (cfg_wr_en) begin
			case (reg_index_t'(cfg_index))
				REG_SEQ_WAIT:    cfg_q.seq_wait    <= cfg_data;
				REG_NONSEQ_WAIT: cfg_q.nonseq_wait <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front: accept and classify each fetch word
	rpb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.address    (address),
		.sequential (sequential),
		.now        (now),
		.push       (push),
		.push_data  (push_data),
		.q_full     (q_full)
	);

	// queue: decouple the front from the fill sequencer
	rpb_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (q_data),
		.empty     (q_empty)
	);

	// back: advance the buffer, resolve hit or miss, drive the result word
	rpb_back #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_empty    (q_empty),
		.q_data     (q_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.stall_res  (stall_res),
		.rom_offset (rom_offset)
	);

endmodule

[hdl/rpb_front.sv]
// Front end: accepts fetch words, classifies them and pushes them into the queue.
module rpb_front
	import rpb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [27:0] address,
	input  logic        sequential,
	input  logic [31:0] now,
	output logic        push,
	output rpb_entry_t  push_data,
	input  logic        q_full
);

	logic       valid_s1;
	rpb_entry_t entry_s1;
	rpb_entry_t entry_new;

	always_comb begin
		entry_new.word       = kind;
		entry_new.address    = address;
		entry_new.sequential = sequential;
		entry_new.now        = now;
		entry_new.blk_start  = ((address & BLOCK_MASK) == 28'd0);
		entry_new.rom_offset = 25'(address - ROM_BASE_ADDR);
	end

	assign push      = valid_s1 && !q_full;
	assign push_data = entry_s1;
	assign in_ready  = !valid_s1 || push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			entry_s1 <= entry_new;
		end
	end

endmodule

[hdl/rpb_fifo.sv]
// Short queue of classified fetches between the front end and the back end.
module rpb_fifo
	import rpb_pkg::*;
#(
	parameter int DEPTH = RPB_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  rpb_entry_t push_data,
	output logic       full,
	input  logic       pop,
	output rpb_entry_t pop_data,
	output logic       empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rpb_entry_t    mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == CW'(0));
	assign pop_data = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == AW'(DEPTH - 1)) ? AW'(0) : p + AW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[hdl/rpb_back.sv]
// Back end: fill catch-up sequencer, hit/miss resolution and result register.
module rpb_back
	import rpb_pkg::*;
#(
	parameter int BUFFER_DEPTH = RPB_BUFFER_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_empty,
	input  rpb_entry_t  q_data,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  stall_res,
	output logic [24:0] rom_offset
);

	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILL,
		ST_RESOLVE
	} state_t;

	state_t            state_q;
	rpb_entry_t        cur_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [31:0]       fill_q;
	logic [31:0]       elapsed_q;
	logic [28:0]       expected_q;
	logic              out_valid_q;
	logic [5:0]        stall_res_q;
	logic [24:0]       rom_offset_q;

	logic [4:0]        period;
	logic              fill_go;
	logic              hit;
	logic              have_need;
	logic [CNT_W-1:0]  need;
	logic              res_fire;
	logic [5:0]        stall_nxt;

	assign period  = {1'b0, cfg.seq_wait} + 5'd1;
	assign fill_go = (cnt_q < CNT_W'(BUFFER_DEPTH)) && (elapsed_q >= {27'd0, period});
	assign pop     = (state_q == ST_IDLE) && !q_empty;

	assign hit       = ({1'b0, cur_q.address} == expected_q);
	assign need      = cur_q.word ? CNT_W'(2) : CNT_W'(1);
	assign have_need = (cnt_q >= need);
	assign res_fire  = (state_q == ST_RESOLVE) && (!out_valid_q || out_ready);

	always_comb begin
		stall_nxt = 6'd0;
		if (hit) begin
			if (!have_need) begin
				// elapsed is below one period here
				stall_nxt = {1'b0, period} - {1'b0, elapsed_q[4:0]};
				if (cur_q.word && cnt_q == CNT_W'(0)) begin
					stall_nxt = stall_nxt + {1'b0, period};
				end
			end
		end else begin
			if (cur_q.blk_start && elapsed_q == 32'd0) begin
				stall_nxt = 6'd1;
			end
			stall_nxt = stall_nxt + {2'd0, (cur_q.sequential ? cfg.seq_wait : cfg.nonseq_wait)};
			if (cur_q.word) begin
				stall_nxt = stall_nxt + {1'b0, period};
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign stall_res  = stall_res_q;
	assign rom_offset = rom_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_q        <= '0;
			cnt_q        <= '0;
			fill_q       <= '0;
			elapsed_q    <= '0;
			expected_q   <= '0;
			out_valid_q  <= 1'b0;
			stall_res_q  <= '0;
			rom_offset_q <= '0;
		end else begin
			if (out_valid_q && out_ready && !res_fire) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						cur_q     <= q_data;
						elapsed_q <= q_data.now - fill_q;
						state_q   <= ST_FILL;
					end
				end
				ST_FILL: begin
					// add one halfword per elapsed sequential access time
					if (fill_go) begin
						cnt_q     <= cnt_q + CNT_W'(1);
						fill_q    <= fill_q + {27'd0, period};
						elapsed_q <= elapsed_q - {27'd0, period};
					end else begin
						state_q <= ST_RESOLVE;
					end
				end
				ST_RESOLVE: begin
					if (res_fire) begin
						if (hit && have_need) begin
							cnt_q <= cnt_q - need;
						end else begin
							cnt_q  <= '0;
							fill_q <= cur_q.now + {26'd0, stall_nxt};
						end
						expected_q   <= {1'b0, cur_q.address} +
							(cur_q.word ? 29'd4 : 29'd2);
						stall_res_q  <= stall_nxt;
						rom_offset_q <= cur_q.rom_offset;
						out_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(BUFFER_DEPTH))
		else $error("buffered count above depth");

	a_fill_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |=> (cnt_q >= $past(cnt_q)))
		else $error("buffered count dropped during fill");

	a_short_hit_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESOLVE && hit && !have_need) |-> (elapsed_q < {27'd0, period}))
		else $error("short hit with a full period pending");

	a_stall_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire |-> (stall_nxt <= 6'd32))
		else $error("stall out of range");

endmodule
